>>> hw/rtl/cpu65_pkg.sv
`default_nettype none
package cpu65_pkg;

  // input actions
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_RESET = 2'd2;
  localparam logic [1:0] ACT_EXEC  = 2'd3;

  // status bit positions
  localparam int FL_C = 0;
  localparam int FL_Z = 1;
  localparam int FL_I = 2;
  localparam int FL_D = 3;
  localparam int FL_B = 4;
  localparam int FL_U = 5;
  localparam int FL_V = 6;
  localparam int FL_N = 7;

  localparam logic [7:0]  SP_RESET    = 8'hFD;
  localparam logic [7:0]  P_RESET     = 8'b0010_0100;
  localparam logic [15:0] RST_VECTOR  = 16'hFFFC;
  localparam logic [7:0]  STACK_PAGE  = 8'h01;

  // addressing modes
  localparam logic [3:0] M_IMM = 4'd0;
  localparam logic [3:0] M_ZP  = 4'd1;
  localparam logic [3:0] M_ZPX = 4'd2;
  localparam logic [3:0] M_ZPY = 4'd3;
  localparam logic [3:0] M_ABS = 4'd4;
  localparam logic [3:0] M_ABX = 4'd5;
  localparam logic [3:0] M_ABY = 4'd6;
  localparam logic [3:0] M_INX = 4'd7;
  localparam logic [3:0] M_INY = 4'd8;

  // opcodes handled outside the regular groups
  localparam logic [7:0] OP_BRK = 8'h00;
  localparam logic [7:0] OP_PHP = 8'h08;
  localparam logic [7:0] OP_PLP = 8'h28;
  localparam logic [7:0] OP_PHA = 8'h48;
  localparam logic [7:0] OP_PLA = 8'h68;
  localparam logic [7:0] OP_CLC = 8'h18;
  localparam logic [7:0] OP_SEC = 8'h38;
  localparam logic [7:0] OP_CLI = 8'h58;
  localparam logic [7:0] OP_SEI = 8'h78;
  localparam logic [7:0] OP_CLV = 8'hB8;
  localparam logic [7:0] OP_CLD = 8'hD8;
  localparam logic [7:0] OP_SED = 8'hF8;
  localparam logic [7:0] OP_DEY = 8'h88;
  localparam logic [7:0] OP_INY = 8'hC8;
  localparam logic [7:0] OP_DEX = 8'hCA;
  localparam logic [7:0] OP_INX = 8'hE8;
  localparam logic [7:0] OP_TXA = 8'h8A;
  localparam logic [7:0] OP_TAX = 8'hAA;
  localparam logic [7:0] OP_TYA = 8'h98;
  localparam logic [7:0] OP_TAY = 8'hA8;
  localparam logic [7:0] OP_TXS = 8'h9A;
  localparam logic [7:0] OP_TSX = 8'hBA;
  localparam logic [7:0] OP_NOP = 8'hEA;
  localparam logic [7:0] OP_ASLA = 8'h0A;
  localparam logic [7:0] OP_ROLA = 8'h2A;
  localparam logic [7:0] OP_LSRA = 8'h4A;
  localparam logic [7:0] OP_RORA = 8'h6A;
  localparam logic [7:0] OP_JMP = 8'h4C;
  localparam logic [7:0] OP_JMPI = 8'h6C;
  localparam logic [7:0] OP_JSR = 8'h20;
  localparam logic [7:0] OP_RTS = 8'h60;
  localparam logic [7:0] OP_RTI = 8'h40;
  localparam logic [7:0] OP_STA_IMM = 8'h89;

  typedef struct packed {
    logic       ok;
    logic [3:0] mode;
  } dec_t;

  // memory-operand decode of the regular aaa/bbb/cc groups
  function automatic dec_t mem_decode(input logic [7:0] op);
    dec_t       d;
    logic [2:0] aaa;
    logic [2:0] bbb;
    aaa    = op[7:5];
    bbb    = op[4:2];
    d.ok   = 1'b0;
    d.mode = M_IMM;
    case (op[1:0])
      2'd1: begin
        d.ok = (op != OP_STA_IMM);
        case (bbb)
          3'd0: d.mode = M_INX;
          3'd1: d.mode = M_ZP;
          3'd2: d.mode = M_IMM;
          3'd3: d.mode = M_ABS;
          3'd4: d.mode = M_INY;
          3'd5: d.mode = M_ZPX;
          3'd6: d.mode = M_ABY;
          default: d.mode = M_ABX;
        endcase
      end
      2'd2: begin
        if (bbb == 3'd0 && aaa == 3'd5) begin
          d.ok = 1'b1; d.mode = M_IMM;
        end else if (bbb == 3'd1) begin
          d.ok = 1'b1; d.mode = M_ZP;
        end else if (bbb == 3'd3) begin
          d.ok = 1'b1; d.mode = M_ABS;
        end else if (bbb == 3'd5) begin
          d.ok = 1'b1;
          d.mode = (aaa == 3'd4 || aaa == 3'd5) ? M_ZPY : M_ZPX;
        end else if (bbb == 3'd7 && aaa != 3'd4) begin
          d.ok = 1'b1;
          d.mode = (aaa == 3'd5) ? M_ABY : M_ABX;
        end
      end
      2'd0: begin
        case (aaa)
          3'd1: d.ok = (bbb == 3'd1 || bbb == 3'd3);
          3'd4: d.ok = (bbb == 3'd1 || bbb == 3'd3 || bbb == 3'd5);
          3'd5: d.ok = (bbb != 3'd2 && bbb != 3'd4 && bbb != 3'd6);
          3'd6, 3'd7: d.ok = (bbb == 3'd0 || bbb == 3'd1 || bbb == 3'd3);
          default: d.ok = 1'b0;
        endcase
        d.mode = (bbb == 3'd0) ? M_IMM : (bbb == 3'd1) ? M_ZP :
                 (bbb == 3'd3) ? M_ABS : (bbb == 3'd5) ? M_ZPX : M_ABX;
      end
      default: d.ok = 1'b0;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] set_zn(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] q;
    q       = p;
    q[FL_Z] = (v == 8'h00);
    q[FL_N] = v[7];
    return q;
  endfunction

  function automatic logic [7:0] cmp_flags(input logic [7:0] p, input logic [7:0] r,
                                           input logic [7:0] m);
    logic [7:0] q;
    q       = set_zn(p, r - m);
    q[FL_C] = (r >= m);
    return q;
  endfunction

  // returns {flags, result}
  function automatic logic [15:0] add_op(input logic [7:0] p, input logic [7:0] a,
                                         input logic [7:0] m);
    logic [8:0] s;
    logic [7:0] r;
    logic [7:0] q;
    s       = {1'b0, a} + {1'b0, m} + {8'h00, p[FL_C]};
    r       = s[7:0];
    q       = set_zn(p, r);
    q[FL_C] = s[8];
    q[FL_V] = (m[7] ^ r[7]) & (a[7] ^ r[7]);
    return {q, r};
  endfunction

  // kind: 0 ASL, 1 ROL, 2 LSR, 3 ROR; returns {flags, result}
  function automatic logic [15:0] shift_op(input logic [7:0] p, input logic [1:0] kind,
                                           input logic [7:0] v);
    logic [7:0] r;
    logic [7:0] q;
    q = p;
    if (!kind[1]) begin
      q[FL_C] = v[7];
      r = {v[6:0], kind[0] & p[FL_C]};
    end else begin
      q[FL_C] = v[0];
      r = {kind[0] & p[FL_C], v[7:1]};
    end
    q = set_zn(q, r);
    return {q, r};
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/cpu65_ram.sv
`default_nettype none
module cpu65_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/cpu_6502_instruction_execute.sv
`default_nettype none
// 6502 core with its own 64 KiB byte memory in one single-port-read,
// single-port-write synchronous RAM. Each input beat writes a byte, reads a
// byte, resets the core (PC from the vector at FFFC) or executes one
// instruction; each gives one result beat with the registers, status,
// halted flag and the read byte. A sequencer makes one RAM access per
// cycle; an instruction steps through opcode fetch, operand bytes,
// pointer bytes, data and write-back, while a halted core goes straight
// to the result register. The next beat is taken while a result still
// waits. After rst_n the memory is swept to zero, one byte per cycle, so
// input is stalled until the sweep ends. BRK halts the core until a reset
// action; decimal mode has no effect.
module cpu_6502_instruction_execute #(
  parameter int MEM_BYTES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_write_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_pc_out,
  output logic [7:0]       out_acc_out,
  output logic [7:0]       out_x_out,
  output logic [7:0]       out_y_out,
  output logic [7:0]       out_sp_out,
  output logic [7:0]       out_flags_out,
  output logic             out_halted,
  output logic [7:0]       out_read_byte
);

  localparam int AW = $clog2(MEM_BYTES);

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_RDW   = 5'd2;
  localparam logic [4:0] S_RST1  = 5'd3;
  localparam logic [4:0] S_RST2  = 5'd4;
  localparam logic [4:0] S_OP    = 5'd5;
  localparam logic [4:0] S_A1    = 5'd6;
  localparam logic [4:0] S_A2    = 5'd7;
  localparam logic [4:0] S_P1    = 5'd8;
  localparam logic [4:0] S_P2    = 5'd9;
  localparam logic [4:0] S_EX    = 5'd10;
  localparam logic [4:0] S_BR    = 5'd11;
  localparam logic [4:0] S_PL    = 5'd12;
  localparam logic [4:0] S_J1    = 5'd13;
  localparam logic [4:0] S_J2    = 5'd14;
  localparam logic [4:0] S_J3    = 5'd15;
  localparam logic [4:0] S_J4    = 5'd16;
  localparam logic [4:0] S_JS1   = 5'd17;
  localparam logic [4:0] S_JS2   = 5'd18;
  localparam logic [4:0] S_JS3   = 5'd19;
  localparam logic [4:0] S_JS4   = 5'd20;
  localparam logic [4:0] S_R1    = 5'd21;
  localparam logic [4:0] S_R2    = 5'd22;
  localparam logic [4:0] S_I1    = 5'd23;
  localparam logic [4:0] S_I2    = 5'd24;
  localparam logic [4:0] S_I3    = 5'd25;
  localparam logic [4:0] S_DONE  = 5'd26;

  // architectural state
  logic [4:0]    state_r, state_nxt;
  logic [7:0]    a_r, a_nxt;
  logic [7:0]    x_r, x_nxt;
  logic [7:0]    y_r, y_nxt;
  logic [7:0]    sp_r, sp_nxt;
  logic [7:0]    p_r, p_nxt;
  logic [15:0]   pc_r, pc_nxt;
  logic          halt_r, halt_nxt;
  // sequencer scratch
  logic [7:0]    op_r, op_nxt;
  logic [3:0]    mode_r, mode_nxt;
  logic [7:0]    lo_r, lo_nxt;
  logic [7:0]    zp_r, zp_nxt;
  logic [15:0]   ea_r, ea_nxt;
  logic [7:0]    rb_r, rb_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  // result register
  logic          ov_r, ov_nxt;
  logic [15:0]   opc_r;
  logic [7:0]    oa_r, ox_r, oy_r, osp_r, op_flags_r, orb_r;
  logic          oh_r;

  // RAM side
  logic          ram_we;
  logic [15:0]   wa16, ra16;
  logic [7:0]    ram_wdata, ram_rdata;

  logic          load_out;
  logic [7:0]    m;
  logic [15:0]   pc1;
  logic [15:0]   tmp16;
  logic [15:0]   res16;
  cpu65_pkg::dec_t dec;
  logic [7:0]    sel_flag;

  cpu65_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wa16[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ra16[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign load_out = (state_r == S_DONE) && (!ov_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    sp_nxt    = sp_r;
    p_nxt     = p_r;
    pc_nxt    = pc_r;
    halt_nxt  = halt_r;
    op_nxt    = op_r;
    mode_nxt  = mode_r;
    lo_nxt    = lo_r;
    zp_nxt    = zp_r;
    ea_nxt    = ea_r;
    rb_nxt    = rb_r;
    clr_nxt   = clr_r;
    ram_we    = 1'b0;
    wa16      = 16'h0000;
    ram_wdata = 8'h00;
    ra16      = pc_r;
    m         = ram_rdata;
    pc1       = pc_r + 16'd1;
    tmp16     = 16'h0000;
    res16     = 16'h0000;
    dec       = cpu65_pkg::mem_decode(ram_rdata);
    sel_flag  = 8'h00;

    unique case (state_r)
      S_CLEAR: begin
        ram_we  = 1'b1;
        wa16    = 16'(clr_r);
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(MEM_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        rb_nxt = 8'h00;
        if (in_valid) begin
          unique case (in_action)
            cpu65_pkg::ACT_WRITE: begin
              ram_we    = 1'b1;
              wa16      = in_address;
              ram_wdata = in_write_byte;
              state_nxt = S_DONE;
            end
            cpu65_pkg::ACT_READ: begin
              ra16      = in_address;
              state_nxt = S_RDW;
            end
            cpu65_pkg::ACT_RESET: begin
              a_nxt     = 8'h00;
              x_nxt     = 8'h00;
              y_nxt     = 8'h00;
              sp_nxt    = cpu65_pkg::SP_RESET;
              p_nxt     = cpu65_pkg::P_RESET;
              halt_nxt  = 1'b0;
              ra16      = cpu65_pkg::RST_VECTOR;
              state_nxt = S_RST1;
            end
            default: begin
              ra16      = pc_r;
              state_nxt = halt_r ? S_DONE : S_OP;
            end
          endcase
        end
      end

      S_RDW: begin
        rb_nxt    = ram_rdata;
        state_nxt = S_DONE;
      end

      S_RST1: begin
        lo_nxt    = ram_rdata;
        ra16      = cpu65_pkg::RST_VECTOR + 16'd1;
        state_nxt = S_RST2;
      end

      S_RST2: begin
        pc_nxt    = {ram_rdata, lo_r};
        state_nxt = S_DONE;
      end

      // opcode byte arrives; PC steps past it
      S_OP: begin
        op_nxt    = ram_rdata;
        pc_nxt    = pc1;
        state_nxt = S_DONE;
        if (ram_rdata[4:0] == 5'h10) begin
          ra16      = pc1;
          state_nxt = S_BR;
        end else begin
          case (ram_rdata)
            cpu65_pkg::OP_BRK: halt_nxt = 1'b1;
            cpu65_pkg::OP_PHP, cpu65_pkg::OP_PHA: begin
              ram_we    = 1'b1;
              wa16      = {cpu65_pkg::STACK_PAGE, sp_r};
              ram_wdata = (ram_rdata == cpu65_pkg::OP_PHA) ? a_r : (p_r | 8'h30);
              sp_nxt    = sp_r - 8'd1;
            end
            cpu65_pkg::OP_PLP, cpu65_pkg::OP_PLA: begin
              sp_nxt    = sp_r + 8'd1;
              ra16      = {cpu65_pkg::STACK_PAGE, sp_r + 8'd1};
              state_nxt = S_PL;
            end
            cpu65_pkg::OP_CLC: p_nxt[cpu65_pkg::FL_C] = 1'b0;
            cpu65_pkg::OP_SEC: p_nxt[cpu65_pkg::FL_C] = 1'b1;
            cpu65_pkg::OP_CLI: p_nxt[cpu65_pkg::FL_I] = 1'b0;
            cpu65_pkg::OP_SEI: p_nxt[cpu65_pkg::FL_I] = 1'b1;
            cpu65_pkg::OP_CLV: p_nxt[cpu65_pkg::FL_V] = 1'b0;
            cpu65_pkg::OP_CLD: p_nxt[cpu65_pkg::FL_D] = 1'b0;
            cpu65_pkg::OP_SED: p_nxt[cpu65_pkg::FL_D] = 1'b1;
            cpu65_pkg::OP_DEY: begin
              y_nxt = y_r - 8'd1; p_nxt = cpu65_pkg::set_zn(p_r, y_r - 8'd1);
            end
            cpu65_pkg::OP_INY: begin
              y_nxt = y_r + 8'd1; p_nxt = cpu65_pkg::set_zn(p_r, y_r + 8'd1);
            end
            cpu65_pkg::OP_DEX: begin
              x_nxt = x_r - 8'd1; p_nxt = cpu65_pkg::set_zn(p_r, x_r - 8'd1);
            end
            cpu65_pkg::OP_INX: begin
              x_nxt = x_r + 8'd1; p_nxt = cpu65_pkg::set_zn(p_r, x_r + 8'd1);
            end
            cpu65_pkg::OP_TXA: begin
              a_nxt = x_r; p_nxt = cpu65_pkg::set_zn(p_r, x_r);
            end
            cpu65_pkg::OP_TAX: begin
              x_nxt = a_r; p_nxt = cpu65_pkg::set_zn(p_r, a_r);
            end
            cpu65_pkg::OP_TYA: begin
              a_nxt = y_r; p_nxt = cpu65_pkg::set_zn(p_r, y_r);
            end
            cpu65_pkg::OP_TAY: begin
              y_nxt = a_r; p_nxt = cpu65_pkg::set_zn(p_r, a_r);
            end
            cpu65_pkg::OP_TXS: sp_nxt = x_r;
            cpu65_pkg::OP_TSX: begin
              x_nxt = sp_r; p_nxt = cpu65_pkg::set_zn(p_r, sp_r);
            end
            cpu65_pkg::OP_ASLA, cpu65_pkg::OP_ROLA,
            cpu65_pkg::OP_LSRA, cpu65_pkg::OP_RORA: begin
              res16 = cpu65_pkg::shift_op(p_r, ram_rdata[6:5], a_r);
              p_nxt = res16[15:8];
              a_nxt = res16[7:0];
            end
            cpu65_pkg::OP_JMP, cpu65_pkg::OP_JMPI: begin
              ra16      = pc1;
              state_nxt = S_J1;
            end
            cpu65_pkg::OP_JSR: begin
              // return address is the last operand byte: opcode + 2
              tmp16     = pc_r + 16'd2;
              ram_we    = 1'b1;
              wa16      = {cpu65_pkg::STACK_PAGE, sp_r};
              ram_wdata = tmp16[15:8];
              sp_nxt    = sp_r - 8'd1;
              state_nxt = S_JS1;
            end
            cpu65_pkg::OP_RTS, cpu65_pkg::OP_RTI: begin
              sp_nxt    = sp_r + 8'd1;
              ra16      = {cpu65_pkg::STACK_PAGE, sp_r + 8'd1};
              state_nxt = (ram_rdata == cpu65_pkg::OP_RTS) ? S_R1 : S_I1;
            end
            default: begin
              // regular groups; anything undecoded is a one-byte NOP
              if (dec.ok) begin
                mode_nxt  = dec.mode;
                ra16      = pc1;
                state_nxt = S_A1;
              end
            end
          endcase
        end
      end

      // first operand byte; pc_r points at it
      S_A1: begin
        pc_nxt = pc1;
        case (mode_r)
          cpu65_pkg::M_IMM: begin
            ea_nxt = pc_r; ra16 = pc_r; state_nxt = S_EX;
          end
          cpu65_pkg::M_ZP: begin
            ea_nxt = {8'h00, ram_rdata}; ra16 = {8'h00, ram_rdata}; state_nxt = S_EX;
          end
          cpu65_pkg::M_ZPX: begin
            ea_nxt = {8'h00, ram_rdata + x_r}; ra16 = {8'h00, ram_rdata + x_r};
            state_nxt = S_EX;
          end
          cpu65_pkg::M_ZPY: begin
            ea_nxt = {8'h00, ram_rdata + y_r}; ra16 = {8'h00, ram_rdata + y_r};
            state_nxt = S_EX;
          end
          cpu65_pkg::M_INX: begin
            zp_nxt = ram_rdata + x_r; ra16 = {8'h00, ram_rdata + x_r}; state_nxt = S_P1;
          end
          cpu65_pkg::M_INY: begin
            zp_nxt = ram_rdata; ra16 = {8'h00, ram_rdata}; state_nxt = S_P1;
          end
          default: begin
            lo_nxt = ram_rdata; ra16 = pc1; state_nxt = S_A2;
          end
        endcase
      end

      S_A2: begin
        pc_nxt = pc1;
        tmp16  = {ram_rdata, lo_r};
        if (mode_r == cpu65_pkg::M_ABX) begin
          tmp16 = tmp16 + {8'h00, x_r};
        end else if (mode_r == cpu65_pkg::M_ABY) begin
          tmp16 = tmp16 + {8'h00, y_r};
        end
        ea_nxt    = tmp16;
        ra16      = tmp16;
        state_nxt = S_EX;
      end

      // zero-page pointer, wraps within page 0
      S_P1: begin
        lo_nxt    = ram_rdata;
        ra16      = {8'h00, zp_r + 8'd1};
        state_nxt = S_P2;
      end

      S_P2: begin
        tmp16 = {ram_rdata, lo_r};
        if (mode_r == cpu65_pkg::M_INY) begin
          tmp16 = tmp16 + {8'h00, y_r};
        end
        ea_nxt    = tmp16;
        ra16      = tmp16;
        state_nxt = S_EX;
      end

      // operand byte m is here; operate and write back
      S_EX: begin
        state_nxt = S_DONE;
        wa16      = ea_r;
        case (op_r[1:0])
          2'd1: begin
            case (op_r[7:5])
              3'd0: begin a_nxt = a_r | m; p_nxt = cpu65_pkg::set_zn(p_r, a_r | m); end
              3'd1: begin a_nxt = a_r & m; p_nxt = cpu65_pkg::set_zn(p_r, a_r & m); end
              3'd2: begin a_nxt = a_r ^ m; p_nxt = cpu65_pkg::set_zn(p_r, a_r ^ m); end
              3'd3: begin
                res16 = cpu65_pkg::add_op(p_r, a_r, m);
                p_nxt = res16[15:8]; a_nxt = res16[7:0];
              end
              3'd4: begin ram_we = 1'b1; ram_wdata = a_r; end
              3'd5: begin a_nxt = m; p_nxt = cpu65_pkg::set_zn(p_r, m); end
              3'd6: p_nxt = cpu65_pkg::cmp_flags(p_r, a_r, m);
              default: begin
                res16 = cpu65_pkg::add_op(p_r, a_r, ~m);
                p_nxt = res16[15:8]; a_nxt = res16[7:0];
              end
            endcase
          end
          2'd2: begin
            case (op_r[7:5])
              3'd4: begin ram_we = 1'b1; ram_wdata = x_r; end
              3'd5: begin x_nxt = m; p_nxt = cpu65_pkg::set_zn(p_r, m); end
              3'd6: begin
                ram_we = 1'b1; ram_wdata = m - 8'd1;
                p_nxt  = cpu65_pkg::set_zn(p_r, m - 8'd1);
              end
              3'd7: begin
                ram_we = 1'b1; ram_wdata = m + 8'd1;
                p_nxt  = cpu65_pkg::set_zn(p_r, m + 8'd1);
              end
              default: begin
                res16  = cpu65_pkg::shift_op(p_r, op_r[6:5], m);
                p_nxt  = res16[15:8];
                ram_we = 1'b1; ram_wdata = res16[7:0];
              end
            endcase
          end
          default: begin
            case (op_r[7:5])
              3'd1: begin
                p_nxt[cpu65_pkg::FL_Z] = ((a_r & m) == 8'h00);
                p_nxt[cpu65_pkg::FL_N] = m[7];
                p_nxt[cpu65_pkg::FL_V] = m[6];
              end
              3'd4: begin ram_we = 1'b1; ram_wdata = y_r; end
              3'd5: begin y_nxt = m; p_nxt = cpu65_pkg::set_zn(p_r, m); end
              3'd6: p_nxt = cpu65_pkg::cmp_flags(p_r, y_r, m);
              default: p_nxt = cpu65_pkg::cmp_flags(p_r, x_r, m);
            endcase
          end
        endcase
      end

      // branch offset; bits 7:6 pick N, V, C, Z and bit 5 is the wanted value
      S_BR: begin
        case (op_r[7:6])
          2'd0: sel_flag = p_r & 8'h80;
          2'd1: sel_flag = p_r & 8'h40;
          2'd2: sel_flag = p_r & 8'h01;
          default: sel_flag = p_r & 8'h02;
        endcase
        tmp16 = pc1;
        if (op_r[5] == (sel_flag != 8'h00)) begin
          tmp16 = pc1 + {{8{ram_rdata[7]}}, ram_rdata};
        end
        pc_nxt    = tmp16;
        state_nxt = S_DONE;
      end

      S_PL: begin
        if (op_r == cpu65_pkg::OP_PLA) begin
          a_nxt = ram_rdata;
          p_nxt = cpu65_pkg::set_zn(p_r, ram_rdata);
        end else begin
          p_nxt = (ram_rdata & 8'hEF) | 8'h20;
        end
        state_nxt = S_DONE;
      end

      S_J1: begin
        lo_nxt    = ram_rdata;
        ra16      = pc1;
        state_nxt = S_J2;
      end

      S_J2: begin
        tmp16 = {ram_rdata, lo_r};
        if (op_r == cpu65_pkg::OP_JMP) begin
          pc_nxt    = tmp16;
          state_nxt = S_DONE;
        end else begin
          ea_nxt    = tmp16;
          ra16      = tmp16;
          state_nxt = S_J3;
        end
      end

      // pointer high byte stays in the same page
      S_J3: begin
        lo_nxt    = ram_rdata;
        ra16      = {ea_r[15:8], ea_r[7:0] + 8'd1};
        state_nxt = S_J4;
      end

      S_J4: begin
        pc_nxt    = {ram_rdata, lo_r};
        state_nxt = S_DONE;
      end

      S_JS1: begin
        ram_we    = 1'b1;
        wa16      = {cpu65_pkg::STACK_PAGE, sp_r};
        ram_wdata = pc1[7:0];
        sp_nxt    = sp_r - 8'd1;
        state_nxt = S_JS2;
      end

      // target is read after both pushes land
      S_JS2: begin
        ra16      = pc_r;
        state_nxt = S_JS3;
      end

      S_JS3: begin
        lo_nxt    = ram_rdata;
        ra16      = pc1;
        state_nxt = S_JS4;
      end

      S_JS4: begin
        pc_nxt    = {ram_rdata, lo_r};
        state_nxt = S_DONE;
      end

      S_R1: begin
        lo_nxt    = ram_rdata;
        sp_nxt    = sp_r + 8'd1;
        ra16      = {cpu65_pkg::STACK_PAGE, sp_r + 8'd1};
        state_nxt = S_R2;
      end

      S_R2: begin
        pc_nxt    = {ram_rdata, lo_r} + 16'd1;
        state_nxt = S_DONE;
      end

      S_I1: begin
        p_nxt     = (ram_rdata & 8'hEF) | 8'h20;
        sp_nxt    = sp_r + 8'd1;
        ra16      = {cpu65_pkg::STACK_PAGE, sp_r + 8'd1};
        state_nxt = S_I2;
      end

      S_I2: begin
        lo_nxt    = ram_rdata;
        sp_nxt    = sp_r + 8'd1;
        ra16      = {cpu65_pkg::STACK_PAGE, sp_r + 8'd1};
        state_nxt = S_I3;
      end

      S_I3: begin
        pc_nxt    = {ram_rdata, lo_r};
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign ov_nxt = (ov_r && out_stall) || load_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      a_r     <= 8'h00;
      x_r     <= 8'h00;
      y_r     <= 8'h00;
      sp_r    <= cpu65_pkg::SP_RESET;
      p_r     <= cpu65_pkg::P_RESET;
      pc_r    <= 16'h0000;
      halt_r  <= 1'b0;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      a_r     <= a_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      sp_r    <= sp_nxt;
      p_r     <= p_nxt;
      pc_r    <= pc_nxt;
      halt_r  <= halt_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    mode_r <= mode_nxt;
    lo_r   <= lo_nxt;
    zp_r   <= zp_nxt;
    ea_r   <= ea_nxt;
    rb_r   <= rb_nxt;
    if (load_out) begin
      opc_r      <= pc_r;
      oa_r       <= a_r;
      ox_r       <= x_r;
      oy_r       <= y_r;
      osp_r      <= sp_r;
      op_flags_r <= p_r;
      oh_r       <= halt_r;
      orb_r      <= rb_r;
    end
  end

  assign out_valid     = ov_r;
  assign out_pc_out    = opc_r;
  assign out_acc_out   = oa_r;
  assign out_x_out     = ox_r;
  assign out_y_out     = oy_r;
  assign out_sp_out    = osp_r;
  assign out_flags_out = op_flags_r;
  assign out_halted    = oh_r;
  assign out_read_byte = orb_r;

endmodule
`default_nettype wire

>>> tb/cpu_6502_core_checker.sv
module cpu_6502_core_checker
  import cpu65_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_pc_out,
  input  logic [7:0]  out_acc_out,
  input  logic [7:0]  out_x_out,
  input  logic [7:0]  out_y_out,
  input  logic [7:0]  out_sp_out,
  input  logic [7:0]  out_flags_out,
  input  logic        out_halted,
  input  logic [7:0]  out_read_byte,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // aaa field of the regular opcode groups
  localparam logic [2:0] G1_ORA = 3'd0, G1_AND = 3'd1, G1_EOR = 3'd2, G1_ADC = 3'd3;
  localparam logic [2:0] G1_STA = 3'd4, G1_LDA = 3'd5, G1_CMP = 3'd6, G1_SBC = 3'd7;
  localparam logic [2:0] G2_ASL = 3'd0, G2_ROL = 3'd1, G2_LSR = 3'd2, G2_ROR = 3'd3;
  localparam logic [2:0] G2_STX = 3'd4, G2_LDX = 3'd5, G2_DEC = 3'd6, G2_INC = 3'd7;
  localparam logic [2:0] G0_BIT = 3'd1, G0_STY = 3'd4, G0_LDY = 3'd5, G0_CPY = 3'd6;
  localparam logic [2:0] G0_CPX = 3'd7;

  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  p;
    logic        halt;
    logic [7:0]  rdata;
  } cpu_view_t;

  logic [7:0]  ram [0:65535];
  logic [7:0]  a_r, x_r, y_r, s_r, p_r;
  logic [15:0] pc_r;
  logic        halt_r;
  cpu_view_t   expected_views[$];

  assign pending = expected_views.size();

  function automatic logic [15:0] rd16(input logic [15:0] ad);
    logic [15:0] nx;
    nx = ad + 16'd1;
    return {ram[nx], ram[ad]};
  endfunction

  task automatic set_zn(input logic [7:0] v);
    p_r[FL_Z] = (v == 8'h00);
    p_r[FL_N] = v[7];
  endtask

  task automatic push8(input logic [7:0] v);
    ram[{STACK_PAGE, s_r}] = v;
    s_r = s_r - 8'd1;
  endtask

  task automatic pull8(output logic [7:0] v);
    s_r = s_r + 8'd1;
    v = ram[{STACK_PAGE, s_r}];
  endtask

  task automatic operand_addr(input logic [3:0] mode, output logic [15:0] ad);
    logic [15:0] p;
    logic [7:0]  z, z1;
    p = pc_r;
    case (mode)
      M_IMM: ad = p;
      M_ZP:  ad = {8'h00, ram[p]};
      M_ZPX: begin z = ram[p] + x_r; ad = {8'h00, z}; end
      M_ZPY: begin z = ram[p] + y_r; ad = {8'h00, z}; end
      M_ABS: ad = rd16(p);
      M_ABX: ad = rd16(p) + {8'h00, x_r};
      M_ABY: ad = rd16(p) + {8'h00, y_r};
      M_INX: begin
        z = ram[p] + x_r;
        z1 = z + 8'd1;
        ad = {ram[{8'h00, z1}], ram[{8'h00, z}]};
      end
      default: begin
        z = ram[p];
        z1 = z + 8'd1;
        ad = {ram[{8'h00, z1}], ram[{8'h00, z}]} + {8'h00, y_r};
      end
    endcase
    pc_r = p + ((mode == M_ABS || mode == M_ABX || mode == M_ABY) ? 16'd2 : 16'd1);
  endtask

  task automatic add_acc(input logic [7:0] m);
    logic [8:0] s;
    logic [7:0] r;
    s = {1'b0, a_r} + {1'b0, m} + {8'h00, p_r[FL_C]};
    r = s[7:0];
    p_r[FL_C] = s[8];
    p_r[FL_V] = (m[7] ^ r[7]) & (a_r[7] ^ r[7]);
    a_r = r;
    set_zn(r);
  endtask

  task automatic compare(input logic [7:0] reg_v, input logic [7:0] m);
    logic [7:0] d;
    d = reg_v - m;
    p_r[FL_C] = (reg_v >= m);
    set_zn(d);
  endtask

  task automatic shift_rot(input logic [2:0] kind, input logic [7:0] v, output logic [7:0] r);
    logic cin;
    cin = p_r[FL_C];
    if (kind == G2_ASL || kind == G2_ROL) begin
      p_r[FL_C] = v[7];
      r = {v[6:0], (kind == G2_ROL) & cin};
    end else begin
      p_r[FL_C] = v[0];
      r = {(kind == G2_ROR) & cin, v[7:1]};
    end
    set_zn(r);
  endtask

  task automatic run_group(input logic [7:0] op);
    logic [2:0]  aaa, bbb;
    logic [3:0]  mode;
    logic [15:0] ad;
    logic [7:0]  m;
    aaa = op[7:5];
    bbb = op[4:2];
    case (op[1:0])
      2'd1: begin
        if (op == OP_STA_IMM) return;
        case (bbb)
          3'd0: mode = M_INX;
          3'd1: mode = M_ZP;
          3'd2: mode = M_IMM;
          3'd3: mode = M_ABS;
          3'd4: mode = M_INY;
          3'd5: mode = M_ZPX;
          3'd6: mode = M_ABY;
          default: mode = M_ABX;
        endcase
        operand_addr(mode, ad);
        case (aaa)
          G1_ORA: begin a_r = a_r | ram[ad]; set_zn(a_r); end
          G1_AND: begin a_r = a_r & ram[ad]; set_zn(a_r); end
          G1_EOR: begin a_r = a_r ^ ram[ad]; set_zn(a_r); end
          G1_ADC: add_acc(ram[ad]);
          G1_STA: ram[ad] = a_r;
          G1_LDA: begin a_r = ram[ad]; set_zn(a_r); end
          G1_CMP: compare(a_r, ram[ad]);
          default: add_acc(~ram[ad]);
        endcase
      end
      2'd2: begin
        if (bbb == 3'd0 && aaa == G2_LDX) mode = M_IMM;
        else if (bbb == 3'd1) mode = M_ZP;
        else if (bbb == 3'd3) mode = M_ABS;
        else if (bbb == 3'd5) mode = (aaa == G2_STX || aaa == G2_LDX) ? M_ZPY : M_ZPX;
        else if (bbb == 3'd7 && aaa != G2_STX) mode = (aaa == G2_LDX) ? M_ABY : M_ABX;
        else return;
        operand_addr(mode, ad);
        if (aaa <= G2_ROR) begin
          shift_rot(aaa, ram[ad], m);
          ram[ad] = m;
        end else if (aaa == G2_STX) ram[ad] = x_r;
        else if (aaa == G2_LDX) begin
          x_r = ram[ad];
          set_zn(x_r);
        end else begin
          m = (aaa == G2_INC) ? ram[ad] + 8'd1 : ram[ad] - 8'd1;
          ram[ad] = m;
          set_zn(m);
        end
      end
      2'd0: begin
        case (aaa)
          G0_BIT: if (!(bbb == 3'd1 || bbb == 3'd3)) return;
          G0_STY: if (!(bbb == 3'd1 || bbb == 3'd3 || bbb == 3'd5)) return;
          G0_LDY: if (bbb == 3'd2 || bbb == 3'd4 || bbb == 3'd6) return;
          G0_CPY, G0_CPX: if (!(bbb == 3'd0 || bbb == 3'd1 || bbb == 3'd3)) return;
          default: return;
        endcase
        mode = (bbb == 3'd0) ? M_IMM : (bbb == 3'd1) ? M_ZP : (bbb == 3'd3) ? M_ABS :
               (bbb == 3'd5) ? M_ZPX : M_ABX;
        operand_addr(mode, ad);
        m = ram[ad];
        case (aaa)
          G0_BIT: begin
            p_r[FL_Z] = ((a_r & m) == 8'h00);
            p_r[FL_N] = m[7];
            p_r[FL_V] = m[6];
          end
          G0_STY: ram[ad] = y_r;
          G0_LDY: begin y_r = m; set_zn(y_r); end
          G0_CPY: compare(y_r, m);
          default: compare(x_r, m);
        endcase
      end
      default: ;
    endcase
  endtask

  task automatic run_instruction();
    logic [7:0]  op, off, lo, hi;
    logic [15:0] p, t;
    logic        have;
    op = ram[pc_r];
    p = pc_r + 16'd1;
    pc_r = p;
    if (op[4:0] == 5'h10) begin
      case (op[7:6])
        2'd0: have = p_r[FL_N];
        2'd1: have = p_r[FL_V];
        2'd2: have = p_r[FL_C];
        default: have = p_r[FL_Z];
      endcase
      off = ram[p];
      pc_r = p + 16'd1;
      if (op[5] == have) pc_r = pc_r + {{8{off[7]}}, off};
      return;
    end
    case (op)
      OP_BRK: halt_r = 1'b1;
      OP_PHP: push8(p_r | 8'h30);
      OP_PLP: begin pull8(lo); p_r = (lo & 8'hEF) | 8'h20; end
      OP_PHA: push8(a_r);
      OP_PLA: begin pull8(a_r); set_zn(a_r); end
      OP_CLC: p_r[FL_C] = 1'b0;
      OP_SEC: p_r[FL_C] = 1'b1;
      OP_CLI: p_r[FL_I] = 1'b0;
      OP_SEI: p_r[FL_I] = 1'b1;
      OP_CLV: p_r[FL_V] = 1'b0;
      OP_CLD: p_r[FL_D] = 1'b0;
      OP_SED: p_r[FL_D] = 1'b1;
      OP_DEY: begin y_r = y_r - 8'd1; set_zn(y_r); end
      OP_INY: begin y_r = y_r + 8'd1; set_zn(y_r); end
      OP_DEX: begin x_r = x_r - 8'd1; set_zn(x_r); end
      OP_INX: begin x_r = x_r + 8'd1; set_zn(x_r); end
      OP_TXA: begin a_r = x_r; set_zn(a_r); end
      OP_TAX: begin x_r = a_r; set_zn(x_r); end
      OP_TYA: begin a_r = y_r; set_zn(a_r); end
      OP_TAY: begin y_r = a_r; set_zn(y_r); end
      OP_TXS: s_r = x_r;
      OP_TSX: begin x_r = s_r; set_zn(x_r); end
      OP_ASLA, OP_ROLA, OP_LSRA, OP_RORA: shift_rot(op[7:5], a_r, a_r);
      OP_JMP: pc_r = rd16(p);
      OP_JMPI: begin
        t = rd16(p);
        lo = t[7:0] + 8'd1;
        pc_r = {ram[{t[15:8], lo}], ram[t]};
      end
      OP_JSR: begin
        t = p + 16'd1;
        push8(t[15:8]);
        push8(t[7:0]);
        pc_r = rd16(p);
      end
      OP_RTS: begin
        pull8(lo);
        pull8(hi);
        pc_r = {hi, lo} + 16'd1;
      end
      OP_RTI: begin
        pull8(lo);
        p_r = (lo & 8'hEF) | 8'h20;
        pull8(lo);
        pull8(hi);
        pc_r = {hi, lo};
      end
      OP_NOP: ;
      default: run_group(op);
    endcase
  endtask

  task automatic predict(input logic [1:0] act, input logic [15:0] ad, input logic [7:0] wb);
    cpu_view_t v;
    v.rdata = 8'h00;
    case (act)
      ACT_WRITE: ram[ad] = wb;
      ACT_READ:  v.rdata = ram[ad];
      ACT_RESET: begin
        a_r = 8'h00; x_r = 8'h00; y_r = 8'h00;
        s_r = SP_RESET;
        p_r = P_RESET;
        halt_r = 1'b0;
        pc_r = rd16(RST_VECTOR);
      end
      default: if (!halt_r) run_instruction();
    endcase
    v.pc = pc_r; v.a = a_r; v.x = x_r; v.y = y_r;
    v.sp = s_r; v.p = p_r; v.halt = halt_r;
    expected_views.push_back(v);
  endtask

  initial begin
    for (int i = 0; i < 65536; i++) ram[i] = 8'h00;
    a_r = 8'h00; x_r = 8'h00; y_r = 8'h00;
    s_r = SP_RESET;
    p_r = P_RESET;
    pc_r = 16'h0000;
    halt_r = 1'b0;
    mismatches = 0;
  end

  always @(posedge clk) begin
    cpu_view_t got, want;
    if (rst_n) begin
      if (in_valid && !in_stall) predict(in_action, in_address, in_write_byte);
      if (out_valid && !out_stall) begin
        got = '{out_pc_out, out_acc_out, out_x_out, out_y_out, out_sp_out,
                out_flags_out, out_halted, out_read_byte};
        if (expected_views.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: unexpected result beat %p", $realtime, got);
        end else begin
          want = expected_views.pop_front();
          if (got.pc !== want.pc || got.a !== want.a || got.x !== want.x ||
              got.y !== want.y || got.sp !== want.sp || got.p !== want.p ||
              got.halt !== want.halt || got.rdata !== want.rdata) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
          end
        end
      end
    end
  end

endmodule

>>> tb/cpu_6502_instruction_execute_test.sv
module cpu_6502_instruction_execute_test;
  import cpu65_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // idle budget; covers the memory sweep after reset with margin
  localparam int IDLE_LIMIT = 200000;
  localparam int ITEM_TARGET = 1050;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = ACT_WRITE;
  logic [15:0] in_address = 16'h0000;
  logic [7:0]  in_write_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_pc_out;
  logic [7:0]  out_acc_out, out_x_out, out_y_out, out_sp_out, out_flags_out;
  logic        out_halted;
  logic [7:0]  out_read_byte;
  int          mismatches, pending;
  int          beats_sent = 0;
  int          idle_cycles = 0;
  int          result_hold = 0;
  logic        no_gaps = 1'b0;    // burst stretch: neither side idles

  always #6 clk = ~clk;

  cpu_6502_instruction_execute uut (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_address, .in_write_byte,
    .out_valid, .out_stall, .out_pc_out, .out_acc_out, .out_x_out, .out_y_out,
    .out_sp_out, .out_flags_out, .out_halted, .out_read_byte
  );

  cpu_6502_core_checker checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_address, .in_write_byte,
    .out_valid, .out_stall, .out_pc_out, .out_acc_out, .out_x_out, .out_y_out,
    .out_sp_out, .out_flags_out, .out_halted, .out_read_byte,
    .mismatches, .pending
  );

  // result side: after each accepted beat, hold off by a random draw, none in a burst stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      result_hold = 0;
    end else begin
      if (out_valid && !out_stall) result_hold = no_gaps ? 0 : $urandom_range(0, 10);
      if (result_hold > 0) begin
        out_stall <= 1'b1;
        result_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: any stretch with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one input beat; valid stays high into the next call when no gap is drawn
  task automatic send_beat(input logic [1:0] act, input logic [15:0] ad, input logic [7:0] wb);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_address <= ad;
    in_write_byte <= wb;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic write_byte(input logic [15:0] ad, input logic [7:0] wb);
    send_beat(ACT_WRITE, ad, wb);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // random opcode, mostly avoiding BRK so programs run a while
  function automatic logic [7:0] pick_opcode();
    logic [7:0] op;
    op = $urandom_range(0, 255);
    if (op == OP_BRK && $urandom_range(0, 3) != 0) op = OP_NOP;
    return op;
  endfunction

  initial begin
    logic [15:0] org;
    int          len, steps;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, overflow add, JMP indirect page wrap, BRK, halted exec
    write_byte(16'hFFFF, 8'hFF);
    send_beat(ACT_READ, 16'hFFFF, 8'h00);
    send_beat(ACT_READ, 16'h0000, 8'hFF);
    write_byte(RST_VECTOR, 8'h00);
    write_byte(RST_VECTOR + 16'd1, 8'h02);
    write_byte(16'h0200, 8'hA9);       // LDA #$7F
    write_byte(16'h0201, 8'h7F);
    write_byte(16'h0202, 8'h69);       // ADC #$01 -> signed overflow
    write_byte(16'h0203, 8'h01);
    write_byte(16'h0204, OP_JMPI);     // pointer at page end
    write_byte(16'h0205, 8'hFF);
    write_byte(16'h0206, 8'h02);
    write_byte(16'h02FF, 8'h34);
    send_beat(ACT_RESET, 16'hFFFF, 8'hFF);
    repeat (3) send_beat(ACT_EXEC, 16'h0000, 8'h00);
    send_beat(ACT_EXEC, 16'hFFFF, 8'hFF);   // lands on BRK in cleared memory
    send_beat(ACT_EXEC, 16'h0000, 8'h00);   // halted: no change
    send_beat(ACT_RESET, 16'h0000, 8'h00);
    drain();

    // random programs: vector, code bytes, some zero page / stack data, reset, run
    while (beats_sent < ITEM_TARGET) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      org = $urandom;
      if ($urandom_range(0, 1)) org[15:8] = 8'h02;
      write_byte(RST_VECTOR, org[7:0]);
      write_byte(RST_VECTOR + 16'd1, org[15:8]);
      len = $urandom_range(6, 14);
      for (int i = 0; i < len; i++)
        write_byte(org + i[15:0], (i % 3 == 0) ? pick_opcode() : 8'($urandom));
      repeat ($urandom_range(1, 3))
        write_byte({7'h00, 1'($urandom), 8'($urandom)}, 8'($urandom));
      send_beat(ACT_RESET, 16'($urandom), 8'($urandom));
      steps = $urandom_range(4, 10);
      for (int i = 0; i < steps; i++) send_beat(ACT_EXEC, 16'($urandom), 8'($urandom));
      if ($urandom_range(0, 1)) send_beat(ACT_READ, 16'($urandom), 8'($urandom));
      if ($urandom_range(0, 3) == 0)
        send_beat(2'($urandom), 16'($urandom), 8'($urandom));
      if ($urandom_range(0, 7) == 0) drain();
    end
    no_gaps = 1'b0;

    drain();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/cpu65_pkg.sv
hw/rtl/cpu65_ram.sv
hw/rtl/cpu_6502_instruction_execute.sv
tb/cpu_6502_core_checker.sv
tb/cpu_6502_instruction_execute_test.sv
